[src/esps_pkg.sv]
// Shared types and constants of the encoder step pulse scheduler.
`default_nettype none
package esps_pkg;

  localparam int EncSlots = 16;
  localparam int VisitCap = 16;
  localparam int VisitMax = (EncSlots < VisitCap) ? EncSlots : VisitCap;
  localparam int IdxW     = $clog2(EncSlots);
  localparam int ActW     = 5;
  localparam int DurW     = 20;
  localparam int GapW     = 20;
  localparam int CycW     = DurW + 1;
  localparam int CntW     = 8;
  localparam int TimeW    = 32;
  localparam int AluW     = TimeW + 1;
  localparam int AddrW    = 4;
  localparam int DataW    = 32;

  localparam logic [DurW-1:0] DurReset   = DurW'(30000);
  localparam logic [GapW-1:0] GapReset   = GapW'(20000);
  localparam logic [CntW-1:0] LimitReset = CntW'(50);

  typedef enum logic [1:0] {
    RegDuration = 2'd0,
    RegGap      = 2'd1,
    RegLimit    = 2'd2,
    RegActive   = 2'd3
  } reg_addr_e;

  typedef enum logic {
    CmdAdd   = 1'b0,
    CmdSweep = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    DirNone = 2'd0,
    DirCw   = 2'd1,
    DirCcw  = 2'd2
  } dir_e;

  typedef enum logic {
    AluAdd = 1'b0,
    AluSub = 1'b1
  } alu_op_e;

  typedef enum logic [2:0] {
    StIdle,
    StAdd,
    StCycle,
    StElapsed,
    StRelease,
    StPress,
    StDone
  } state_e;

  typedef struct packed {
    logic [DurW-1:0] dur;
    logic [GapW-1:0] gap;
    logic [CntW-1:0] limit;
    logic [ActW-1:0] active;
  } cfg_t;

  typedef struct packed {
    alu_op_e         op;
    logic [AluW-1:0] a;
    logic [AluW-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic            valid;
    logic [IdxW-1:0] enc;
    logic            dir;
    logic            press;
  } evt_t;

endpackage
`default_nettype wire

[src/esps_cfg.sv]
// APB configuration registers of the encoder step pulse scheduler.
`default_nettype none
module esps_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [esps_pkg::AddrW-1:0]    paddr,
  input  logic [esps_pkg::DataW-1:0]    pwdata,
  output logic [esps_pkg::DataW-1:0]    prdata,
  output logic                          pready,
  output esps_pkg::cfg_t                cfg_o
);
  import esps_pkg::*;

  cfg_t      cfg_q, cfg_d;
  reg_addr_e addr;
  logic      wr_en;

  assign pready = 1'b1;
  assign addr   = reg_addr_e'(paddr[AddrW-1:2]);
  assign wr_en  = psel && penable && pwrite && pready;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (addr)
        RegDuration: cfg_d.dur    = pwdata[DurW-1:0];
        RegGap:      cfg_d.gap    = pwdata[GapW-1:0];
        RegLimit:    cfg_d.limit  = pwdata[CntW-1:0];
        RegActive:   cfg_d.active = pwdata[ActW-1:0];
        default:     cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (addr)
      RegDuration: prdata = DataW'(cfg_q.dur);
      RegGap:      prdata = DataW'(cfg_q.gap);
      RegLimit:    prdata = DataW'(cfg_q.limit);
      RegActive:   prdata = DataW'(cfg_q.active);
      default:     prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dur    <= DurReset;
      cfg_q.gap    <= GapReset;
      cfg_q.limit  <= LimitReset;
      cfg_q.active <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule
`default_nettype wire

[src/esps_alu.sv]
// Shared add and subtract unit used for every time sum and compare.
`default_nettype none
module esps_alu (
  input  esps_pkg::alu_req_t            req_i,
  output logic [esps_pkg::AluW-1:0]     res_o
);
  import esps_pkg::*;

  always_comb begin
    case (req_i.op)
      AluSub:  res_o = req_i.a - req_i.b;
      default: res_o = req_i.a + req_i.b;
    endcase
  end

endmodule
`default_nettype wire

[src/esps_ctrl.sv]
// Sequencer and per-encoder state: step accumulation and the sweep over the active entries.
`default_nettype none
module esps_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic                          command_i,
  input  logic [3:0]                    encoder_index_i,
  input  logic                          turn_direction_i,
  input  logic [7:0]                    step_count_i,
  input  logic [31:0]                   now_us_i,
  input  esps_pkg::cfg_t                cfg_i,
  output esps_pkg::alu_req_t            alu_req_o,
  input  logic [esps_pkg::AluW-1:0]     alu_res_i,
  output esps_pkg::evt_t                evt_o,
  output logic                          done_o,
  output logic                          busy_o
);
  import esps_pkg::*;

  state_e st_q, st_d;

  logic [CntW-1:0]  cw_q   [EncSlots];
  logic [CntW-1:0]  ccw_q  [EncSlots];
  logic [TimeW-1:0] time_q [EncSlots];
  logic             held_q [EncSlots];
  dir_e             ldir_q [EncSlots];

  logic [IdxW-1:0]  idx_q, idx_d;
  logic [TimeW-1:0] now_q;
  logic             dir_q;
  logic [CntW-1:0]  steps_q;
  logic [CycW-1:0]  cycle_q;
  logic [TimeW-1:0] elapsed_q;

  logic [CntW-1:0]  cur_cw, cur_ccw, cur_cnt, add_val;
  logic [TimeW-1:0] cur_time;
  logic             cur_held;
  dir_e             cur_ldir, nxt;
  logic [ActW-1:0]  visits;
  logic             last_ent, add_ok, rel_fire, press_fire, want, go;
  logic [CntW:0]    sum;

  assign cur_cw   = cw_q[idx_q];
  assign cur_ccw  = ccw_q[idx_q];
  assign cur_time = time_q[idx_q];
  assign cur_held = held_q[idx_q];
  assign cur_ldir = ldir_q[idx_q];

  assign visits   = (cfg_i.active > ActW'(VisitMax)) ? ActW'(VisitMax) : cfg_i.active;
  assign last_ent = (ActW'(idx_q) + ActW'(1)) == visits;
  assign busy_o   = (st_q != StIdle);

  // Saturating add into the addressed count.
  assign cur_cnt = dir_q ? cur_ccw : cur_cw;
  assign add_ok  = ActW'(idx_q) < cfg_i.active;
  assign sum     = {1'b0, cur_cnt} + {1'b0, steps_q};
  always_comb begin
    if (cur_cnt >= cfg_i.limit) begin
      add_val = cur_cnt;
    end else if (sum > {1'b0, cfg_i.limit}) begin
      add_val = cfg_i.limit;
    end else begin
      add_val = sum[CntW-1:0];
    end
  end

  always_comb begin
    if (cur_ldir == DirCw && cur_cw != '0) begin
      nxt = DirCw;
    end else if (cur_ldir == DirCcw && cur_ccw != '0) begin
      nxt = DirCcw;
    end else if (cur_cw != '0) begin
      nxt = DirCw;
    end else begin
      nxt = DirCcw;
    end
  end

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      StIdle: begin
        if (start_i) begin
          st_d = (cmd_e'(command_i) == CmdSweep) ? StCycle : StAdd;
        end
      end
      StAdd:     st_d = StIdle;
      StCycle:   st_d = (visits == '0) ? StDone : StElapsed;
      StElapsed: st_d = StRelease;
      StRelease: st_d = StPress;
      StPress:   st_d = last_ent ? StDone : StElapsed;
      StDone:    st_d = StIdle;
      default:   st_d = StIdle;
    endcase
  end

  always_comb begin
    alu_req_o  = '{op: AluAdd, a: '0, b: '0};
    evt_o      = '0;
    done_o     = 1'b0;
    rel_fire   = 1'b0;
    press_fire = 1'b0;
    want       = 1'b0;
    go         = 1'b0;
    unique case (st_q)
      StCycle: begin
        alu_req_o = '{op: AluAdd, a: AluW'(cfg_i.dur), b: AluW'(cfg_i.gap)};
      end
      StElapsed: begin
        alu_req_o = '{op: AluSub, a: AluW'(now_q), b: AluW'(cur_time)};
      end
      StRelease: begin
        alu_req_o   = '{op: AluSub, a: AluW'(elapsed_q), b: AluW'(cfg_i.dur)};
        rel_fire    = cur_held && !alu_res_i[AluW-1];
        evt_o.valid = rel_fire;
        evt_o.enc   = idx_q;
        evt_o.dir   = (cur_ldir == DirCw) ? 1'b0 : 1'b1;
        evt_o.press = 1'b0;
      end
      StPress: begin
        alu_req_o   = '{op: AluSub, a: AluW'(elapsed_q), b: AluW'(cycle_q)};
        want        = !cur_held && (cur_cw != '0 || cur_ccw != '0);
        go          = (cur_time == '0) || (nxt != cur_ldir) || !alu_res_i[AluW-1];
        press_fire  = want && go;
        evt_o.valid = press_fire;
        evt_o.enc   = idx_q;
        evt_o.dir   = (nxt == DirCw) ? 1'b0 : 1'b1;
        evt_o.press = 1'b1;
      end
      StDone:  done_o = 1'b1;
      default: done_o = 1'b0;
    endcase
  end

  always_comb begin
    idx_d = idx_q;
    if (st_q == StIdle && start_i) begin
      idx_d = (cmd_e'(command_i) == CmdSweep) ? '0 : encoder_index_i[IdxW-1:0];
    end else if (st_q == StPress && !last_ent) begin
      idx_d = idx_q + IdxW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
    end else begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    if (st_q == StIdle && start_i) begin
      now_q   <= now_us_i;
      dir_q   <= turn_direction_i;
      steps_q <= step_count_i;
    end
    if (st_q == StCycle) begin
      cycle_q <= alu_res_i[CycW-1:0];
    end
    if (st_q == StElapsed) begin
      elapsed_q <= alu_res_i[TimeW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < EncSlots; i++) begin
        cw_q[i]   <= '0;
        ccw_q[i]  <= '0;
        time_q[i] <= '0;
        held_q[i] <= 1'b0;
        ldir_q[i] <= DirNone;
      end
    end else begin
      if (st_q == StAdd && add_ok) begin
        if (dir_q) begin
          ccw_q[idx_q] <= add_val;
        end else begin
          cw_q[idx_q] <= add_val;
        end
      end
      if (rel_fire) begin
        held_q[idx_q] <= 1'b0;
      end
      if (press_fire) begin
        held_q[idx_q] <= 1'b1;
        time_q[idx_q] <= now_q;
        ldir_q[idx_q] <= nxt;
        if (nxt == DirCw) begin
          cw_q[idx_q] <= cur_cw - CntW'(1);
        end else begin
          ccw_q[idx_q] <= cur_ccw - CntW'(1);
        end
      end
    end
  end

endmodule
`default_nettype wire

[src/encoder_step_pulse_scheduler_top.sv]
// Top level of the encoder step pulse scheduler: units and the event output stage.
//
//   Channel   | Ports                                   | Handshake
//   ----------+-----------------------------------------+----------------------------
//   request   | command_i .. now_us_i                   | start, taken when busy low
//   event     | event_encoder_o .. event_last_o         | event_strobe_o, one cycle
//   config    | psel penable pwrite paddr pwdata prdata | APB, pready tied high
//
// An add request keeps busy high while it updates the addressed count. A sweep request
// keeps busy high while it forms the pulse period and visits each entry in turn: each
// entry takes three passes through the shared add and subtract unit. Events leave
// through a one-deep hold register so that the final one can carry event_last_o; the
// final event appears in the same cycle that busy falls. Reset clears all encoder state
// and loads the register defaults. The receiver cannot stall events.
`default_nettype none
module encoder_step_pulse_scheduler_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic                          command_i,
  input  logic [3:0]                    encoder_index_i,
  input  logic                          turn_direction_i,
  input  logic [7:0]                    step_count_i,
  input  logic [31:0]                   now_us_i,
  output logic                          event_strobe_o,
  output logic [3:0]                    event_encoder_o,
  output logic                          event_direction_o,
  output logic                          event_press_o,
  output logic                          event_last_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [esps_pkg::AddrW-1:0]    paddr,
  input  logic [esps_pkg::DataW-1:0]    pwdata,
  output logic [esps_pkg::DataW-1:0]    prdata,
  output logic                          pready
);
  import esps_pkg::*;

  cfg_t            cfg;
  alu_req_t        alu_req;
  logic [AluW-1:0] alu_res;
  evt_t            evt;
  logic            done;

  evt_t hold_q, hold_d;
  logic strobe_q, strobe_d;
  logic last_q, last_d;
  evt_t out_q, out_d;

  esps_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  esps_alu u_alu (
    .req_i (alu_req),
    .res_o (alu_res)
  );

  esps_ctrl u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start),
    .command_i        (command_i),
    .encoder_index_i  (encoder_index_i),
    .turn_direction_i (turn_direction_i),
    .step_count_i     (step_count_i),
    .now_us_i         (now_us_i),
    .cfg_i            (cfg),
    .alu_req_o        (alu_req),
    .alu_res_i        (alu_res),
    .evt_o            (evt),
    .done_o           (done),
    .busy_o           (busy)
  );

  always_comb begin
    hold_d   = hold_q;
    strobe_d = 1'b0;
    last_d   = 1'b0;
    out_d    = hold_q;
    if (evt.valid) begin
      strobe_d = hold_q.valid;
      hold_d   = evt;
    end else if (done) begin
      strobe_d     = hold_q.valid;
      last_d       = 1'b1;
      hold_d.valid = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q   <= '0;
      strobe_q <= 1'b0;
    end else begin
      hold_q   <= hold_d;
      strobe_q <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    last_q <= last_d;
  end

  assign event_strobe_o    = strobe_q;
  assign event_encoder_o   = out_q.enc;
  assign event_direction_o = out_q.dir;
  assign event_press_o     = out_q.press;
  assign event_last_o      = last_q;

endmodule
`default_nettype wire

[test/esps_tb_pkg.sv]
// Button event predictor and checker used by the encoder step pulse scheduler testbench.
package esps_tb_pkg;
  import esps_pkg::*;

  typedef struct packed {
    logic [IdxW-1:0] enc;
    logic            dir;
    logic            press;
    logic            last;
  } button_evt_t;

  class button_event_board;
    logic [DurW-1:0]  duration;
    logic [GapW-1:0]  gap;
    logic [CntW-1:0]  limit;
    logic [ActW-1:0]  active;
    logic [CntW-1:0]  cw_steps   [EncSlots];
    logic [CntW-1:0]  ccw_steps  [EncSlots];
    logic [TimeW-1:0] pressed_at [EncSlots];
    logic             held       [EncSlots];
    dir_e             last_dir   [EncSlots];
    button_evt_t      events_due [$];
    int               mismatches;

    function new();
      duration   = DurReset;
      gap        = GapReset;
      limit      = LimitReset;
      active     = '0;
      mismatches = 0;
      for (int i = 0; i < EncSlots; i++) begin
        cw_steps[i]   = '0;
        ccw_steps[i]  = '0;
        pressed_at[i] = '0;
        held[i]       = 1'b0;
        last_dir[i]   = DirNone;
      end
    endfunction

    function void write_reg(reg_addr_e addr, logic [DataW-1:0] value);
      case (addr)
        RegDuration: duration = value[DurW-1:0];
        RegGap:      gap      = value[GapW-1:0];
        RegLimit:    limit    = value[CntW-1:0];
        RegActive:   active   = value[ActW-1:0];
        default:     ;
      endcase
    endfunction

    function logic [CntW-1:0] add_steps(logic [CntW-1:0] cur, logic [CntW-1:0] n);
      logic [CntW:0] sum;
      if (cur >= limit) return cur;
      sum = cur + n;
      if (sum > limit) sum = {1'b0, limit};
      return sum[CntW-1:0];
    endfunction

    function void take_request(cmd_e cmd, logic [IdxW-1:0] idx, logic dir,
                               logic [CntW-1:0] n, logic [TimeW-1:0] now);
      int               visits;
      int               first;
      int               i;
      logic [TimeW-1:0] elapsed;
      logic [CycW-1:0]  period;
      dir_e             nxt;
      button_evt_t      ev;
      if (cmd == CmdAdd) begin
        if ({1'b0, idx} < active) begin
          if (dir) ccw_steps[idx] = add_steps(ccw_steps[idx], n);
          else cw_steps[idx] = add_steps(cw_steps[idx], n);
        end
        return;
      end
      visits = (int'(active) > VisitMax) ? VisitMax : int'(active);
      period = duration + gap;
      first  = events_due.size();
      for (i = 0; i < visits; i++) begin
        elapsed = now - pressed_at[i];
        if (held[i] && elapsed >= duration) begin
          ev.enc   = IdxW'(i);
          ev.dir   = (last_dir[i] != DirCw);
          ev.press = 1'b0;
          ev.last  = 1'b0;
          events_due.push_back(ev);
          held[i] = 1'b0;
        end
        if (!held[i] && (cw_steps[i] != 0 || ccw_steps[i] != 0)) begin
          if (last_dir[i] == DirCw && cw_steps[i] != 0) nxt = DirCw;
          else if (last_dir[i] == DirCcw && ccw_steps[i] != 0) nxt = DirCcw;
          else if (cw_steps[i] != 0) nxt = DirCw;
          else nxt = DirCcw;
          if (pressed_at[i] == 0 || nxt != last_dir[i] || elapsed >= period) begin
            ev.enc   = IdxW'(i);
            ev.dir   = (nxt == DirCcw);
            ev.press = 1'b1;
            ev.last  = 1'b0;
            events_due.push_back(ev);
            held[i]       = 1'b1;
            pressed_at[i] = now;
            last_dir[i]   = nxt;
            if (nxt == DirCw) cw_steps[i]--;
            else ccw_steps[i]--;
          end
        end
      end
      if (events_due.size() > first) events_due[events_due.size()-1].last = 1'b1;
    endfunction

    function void check_event(button_evt_t got);
      button_evt_t want;
      if (events_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected event: enc %0d dir %0b press %0b last %0b",
                   got.enc, got.dir, got.press, got.last);
        end
        return;
      end
      want = events_due.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("event mismatch: expected enc %0d dir %0b press %0b last %0b, got enc %0d dir %0b press %0b last %0b",
                   want.enc, want.dir, want.press, want.last,
                   got.enc, got.dir, got.press, got.last);
        end
      end
    endfunction

    function int waiting();
      return events_due.size();
    endfunction
  endclass

endpackage

[test/encoder_step_pulse_scheduler_top_tb.sv]
// Testbench for the encoder step pulse scheduler: directed and random requests checked event by event.
module encoder_step_pulse_scheduler_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import esps_pkg::*;
  import esps_tb_pkg::*;

  localparam int CycleLimit  = 400000;
  localparam int DrainCycles = 64;

  logic              clk_i;
  logic              rst_ni;
  logic              start;
  logic              busy;
  logic              command_i;
  logic [3:0]        encoder_index_i;
  logic              turn_direction_i;
  logic [7:0]        step_count_i;
  logic [31:0]       now_us_i;
  logic              event_strobe_o;
  logic [3:0]        event_encoder_o;
  logic              event_direction_o;
  logic              event_press_o;
  logic              event_last_o;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [AddrW-1:0]  paddr;
  logic [DataW-1:0]  pwdata;
  logic [DataW-1:0]  prdata;
  logic              pready;

  button_event_board board;
  logic [TimeW-1:0]  now_t;
  int                cycle_count = 0;

  encoder_step_pulse_scheduler_top u_top (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start             (start),
    .busy              (busy),
    .command_i         (command_i),
    .encoder_index_i   (encoder_index_i),
    .turn_direction_i  (turn_direction_i),
    .step_count_i      (step_count_i),
    .now_us_i          (now_us_i),
    .event_strobe_o    (event_strobe_o),
    .event_encoder_o   (event_encoder_o),
    .event_direction_o (event_direction_o),
    .event_press_o     (event_press_o),
    .event_last_o      (event_last_o),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("encoder_step_pulse_scheduler_top_tb failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && event_strobe_o) begin
      board.check_event({event_encoder_o, event_direction_o, event_press_o, event_last_o});
    end
  end

  task automatic apb_write(reg_addr_e addr, logic [DataW-1:0] value);
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {addr, 2'b00};
    pwdata  = value;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    board.write_reg(addr, value);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic settle();
    @(negedge clk_i);
    start = 1'b0;
    while (busy || board.waiting() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic setup(logic [DataW-1:0] dur, logic [DataW-1:0] gap,
                       logic [DataW-1:0] limit, logic [DataW-1:0] active);
    settle();
    apb_write(RegDuration, dur);
    apb_write(RegGap, gap);
    apb_write(RegLimit, limit);
    apb_write(RegActive, active);
  endtask

  task automatic send_request(logic idle_ok, cmd_e cmd, logic [3:0] idx, logic dir,
                              logic [7:0] n, logic [31:0] now);
    int pause;
    pause = (idle_ok && $urandom_range(0, 2) == 0) ? $urandom_range(1, 11) : 0;
    if (pause > 0) begin
      @(negedge clk_i);
      start = 1'b0;
      repeat (pause) @(posedge clk_i);
    end
    @(negedge clk_i);
    command_i        = cmd;
    encoder_index_i  = idx;
    turn_direction_i = dir;
    step_count_i     = n;
    now_us_i         = now;
    start            = 1'b1;
    do @(posedge clk_i); while (busy);
    board.take_request(cmd, idx, dir, n, now);
  endtask

  task automatic run_random(int items, logic idle_ok);
    int          k;
    int          reach;
    int unsigned span;
    logic [3:0]  idx;
    logic [7:0]  n;
    for (k = 0; k < items; k++) begin
      if ($urandom_range(0, 99) < 55) begin
        reach = (int'(board.active) > EncSlots) ? EncSlots : int'(board.active);
        if (reach != 0 && $urandom_range(0, 7) != 0) idx = 4'($urandom_range(0, reach - 1));
        else idx = 4'($urandom_range(0, 15));
        if ($urandom_range(0, 3) == 0) n = 8'($urandom_range(0, 255));
        else n = 8'($urandom_range(0, 4));
        send_request(idle_ok, CmdAdd, idx, 1'($urandom_range(0, 1)), n, $urandom);
      end else begin
        span = 2 * (int'(board.duration) + int'(board.gap)) + 2;
        case ($urandom_range(0, 19))
          0:       now_t = $urandom;
          1:       ;
          default: now_t += $urandom_range(0, span);
        endcase
        send_request(idle_ok, CmdSweep, 4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)),
                     8'($urandom_range(0, 255)), now_t);
      end
    end
  endtask

  initial begin
    board            = new();
    rst_ni           = 1'b0;
    start            = 1'b0;
    command_i        = CmdAdd;
    encoder_index_i  = '0;
    turn_direction_i = 1'b0;
    step_count_i     = '0;
    now_us_i         = '0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    now_t            = '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // With no active entries after reset, adds are ignored and sweeps stay silent.
    send_request(1'b0, CmdAdd, 4'd0, 1'b0, 8'd5, 32'd0);
    send_request(1'b0, CmdSweep, 4'd0, 1'b0, 8'd0, 32'h0000_1234);

    setup(100, 50, 3, 4);
    send_request(1'b0, CmdAdd, 4'd0, 1'b0, 8'd255, 32'd0);
    send_request(1'b0, CmdAdd, 4'd0, 1'b1, 8'd1, 32'd0);
    send_request(1'b0, CmdAdd, 4'd1, 1'b1, 8'd2, 32'd0);
    send_request(1'b0, CmdAdd, 4'd3, 1'b0, 8'd0, 32'd0);
    send_request(1'b0, CmdAdd, 4'd5, 1'b0, 8'd7, 32'd0);
    send_request(1'b0, CmdAdd, 4'd15, 1'b1, 8'd255, 32'hFFFF_FFFF);
    send_request(1'b0, CmdSweep, 4'd0, 1'b0, 8'd0, 32'd0);
    send_request(1'b0, CmdSweep, 4'd0, 1'b0, 8'd0, 32'd50);
    send_request(1'b0, CmdSweep, 4'd0, 1'b0, 8'd0, 32'd100);
    send_request(1'b0, CmdAdd, 4'd0, 1'b0, 8'd255, 32'd0);
    send_request(1'b0, CmdSweep, 4'd0, 1'b0, 8'd0, 32'd200);
    send_request(1'b0, CmdSweep, 4'd0, 1'b0, 8'd0, 32'd250);
    send_request(1'b0, CmdSweep, 4'd15, 1'b1, 8'd255, 32'hFFFF_FFFF);
    send_request(1'b0, CmdSweep, 4'd0, 1'b0, 8'd0, 32'd99);
    send_request(1'b0, CmdSweep, 4'd0, 1'b0, 8'd0, 32'd149);
    send_request(1'b0, CmdSweep, 4'd0, 1'b0, 8'd0, 32'd400);

    now_t = $urandom;
    setup(1000, 500, 255, 16);
    run_random(59, 1'b1);

    now_t = 32'hFFFF_F000;
    setup(0, 0, 1, 31);
    run_random(59, 1'b1);

    now_t = $urandom;
    setup(1000000, 1000000, 9, 7);
    run_random(59, 1'b1);

    now_t = $urandom;
    setup(300, 0, 0, 16);
    run_random(59, 1'b1);

    now_t = 32'hFFFF_FF00;
    setup(20, 10, 50, 12);
    run_random(59, 1'b0);

    settle();
    if (board.mismatches == 0 && board.waiting() == 0) begin
      $display("encoder_step_pulse_scheduler_top_tb passed");
    end else begin
      $display("encoder_step_pulse_scheduler_top_tb failed");
    end
    $finish;
  end

endmodule

[sim.f]
src/esps_pkg.sv
src/esps_cfg.sv
src/esps_alu.sv
src/esps_ctrl.sv
src/encoder_step_pulse_scheduler_top.sv
test/esps_tb_pkg.sv
test/encoder_step_pulse_scheduler_top_tb.sv
